/* sv/cvg_pkg.sv */
// ----------------------------------------------------------------------------
// cvg_pkg: shared types and constants for the cylinder vertex generator
// Holds field widths, register indexes, CORDIC constants and the cell payload.
// ----------------------------------------------------------------------------
`default_nettype none

package cvg_pkg;

  localparam int unsigned MaxSlicesDef = 256;
  localparam int unsigned CordicSteps  = 20;
  localparam int unsigned VnumW        = 11;
  localparam int unsigned RadiusW      = 15;
  localparam int unsigned LengthW      = 16;
  localparam int unsigned SlicesW      = 9;
  localparam int unsigned AddrW        = 4;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // register byte addresses
  localparam logic [AddrW-1:0] RegRadius = 4'h0;
  localparam logic [AddrW-1:0] RegLength = 4'h4;
  localparam logic [AddrW-1:0] RegSlices = 4'h8;

  // arctangent table in turn units
  function automatic logic signed [33:0] atan_turn(input int unsigned k);
    case (k)
      0: atan_turn = 34'sh020000000;  1: atan_turn = 34'sh012E4051D;
      2: atan_turn = 34'sh009FB385B;  3: atan_turn = 34'sh0051111D4;
      4: atan_turn = 34'sh0028B0D43;  5: atan_turn = 34'sh00145D7E1;
      6: atan_turn = 34'sh000A2F61E;  7: atan_turn = 34'sh000517C55;
      8: atan_turn = 34'sh00028BE53;  9: atan_turn = 34'sh000145F2F;
      10: atan_turn = 34'sh0000A2F98; 11: atan_turn = 34'sh0000517CC;
      12: atan_turn = 34'sh000028BE6; 13: atan_turn = 34'sh0000145F3;
      14: atan_turn = 34'sh00000A2F9; 15: atan_turn = 34'sh00000517C;
      16: atan_turn = 34'sh0000028BE; 17: atan_turn = 34'sh00000145F;
      18: atan_turn = 34'sh000000A2F; 19: atan_turn = 34'sh000000517;
      default: atan_turn = '0;
    endcase
  endfunction

  // data carried by every cell along the chain
  typedef struct packed {
    logic               valid;
    logic               rim;       // needs CORDIC result
    logic               body;      // normal follows the angle
    logic        [1:0]  quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_z;
    logic               ok;
    logic [RadiusW-1:0] radius;
  } cell_t;

endpackage

`default_nettype wire

/* sv/cvg_if.sv */
// ----------------------------------------------------------------------------
// cvg_if: valid/ready channels for vertex numbers and vertex results
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvg_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] vertex_number;
  modport source (output valid, output vertex_number, input ready);
  modport sink   (input valid, input vertex_number, output ready);
endinterface

interface cvg_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic              index_ok;
  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output norm_x, output norm_y, output norm_z,
                  output index_ok, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input norm_x, input norm_y, input norm_z,
                  input index_ok, output ready);
endinterface

`default_nettype wire

/* sv/cvg_div_cell.sv */
// ----------------------------------------------------------------------------
// cvg_div_cell: one restoring-division step of the angle divider
// Produces one quotient bit of floor(i * 2^32 / S) and passes the rest on.
// ----------------------------------------------------------------------------
`default_nettype none

module cvg_div_cell
  import cvg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire cell_t       c_i,
  input  wire logic [9:0]  rem_i,
  input  wire logic [31:0] quo_i,
  input  wire logic [8:0]  div_i,
  input  wire logic        neg_i,
  output cell_t            c_o,
  output logic [9:0]       rem_o,
  output logic [31:0]      quo_o,
  output logic [8:0]       div_o,
  output logic             neg_o
);

  logic [9:0] sh;
  logic       ge;

  // shift in a zero bit, subtract when it fits
  always_comb begin
    sh = {rem_i[8:0], 1'b0};
    ge = (sh >= {1'b0, div_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_o   <= '0;
      rem_o <= '0;
      quo_o <= '0;
      div_o <= '0;
      neg_o <= 1'b0;
    end else if (en_i) begin
      c_o   <= c_i;
      rem_o <= ge ? (sh - {1'b0, div_i}) : sh;
      quo_o <= {quo_i[30:0], ge};
      div_o <= div_i;
      neg_o <= neg_i;
    end
  end

endmodule

`default_nettype wire

/* sv/cvg_cordic_cell.sv */
// ----------------------------------------------------------------------------
// cvg_cordic_cell: one rotation-mode CORDIC micro-rotation
// Stage index K sets the shift and the arctangent constant.
// ----------------------------------------------------------------------------
`default_nettype none

module cvg_cordic_cell
  import cvg_pkg::*;
#(
  parameter int unsigned K = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire cell_t c_i,
  output cell_t      c_o
);

  localparam logic signed [33:0] Atan = atan_turn(K);
  cell_t n;

  // rotate toward zero residual angle
  always_comb begin
    n = c_i;
    if (!c_i.z[33]) begin
      n.x = c_i.x - (c_i.y >>> K);
      n.y = c_i.y + (c_i.x >>> K);
      n.z = c_i.z - Atan;
    end else begin
      n.x = c_i.x + (c_i.y >>> K);
      n.y = c_i.y - (c_i.x >>> K);
      n.z = c_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_o <= '0;
    end else if (en_i) begin
      c_o <= n;
    end
  end

endmodule

`default_nettype wire

/* sv/cylinder_vertex_generator.sv */
// ----------------------------------------------------------------------------
// cylinder_vertex_generator: position and normal of one cylinder vertex
// Decode, angle divider cells, CORDIC cells and output scaling in one chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries a vertex number, out_if one result beat per vertex, in order.
//   Registers radius, length and slices sit on an APB port at 0x0, 0x4, 0x8;
//   write them only while no vertex is in flight.
//   Stages: 1 decode register, 32 divider cells, 20 CORDIC cells and 2 scaling
//   stages lie between accept and result valid.
//   Throughput: one vertex per cycle; the whole chain of cells advances
//   together whenever the last stage is empty or its beat is taken.
//   When the receiver stalls, the chain freezes and in_if.ready goes low
//   once the output stage holds a beat that is not taken.
//   Reset clears all valid bits and loads radius 256, length 512, slices 16.
//   Out-of-range vertex numbers give zero fields with index_ok low.
// ----------------------------------------------------------------------------
`default_nettype none

module cylinder_vertex_generator
  import cvg_pkg::*;
#(
  parameter int unsigned MAX_SLICES = MaxSlicesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  cvg_in_if.sink                  in_if,
  cvg_out_if.source               out_if,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int unsigned DivN = 32;
  localparam int unsigned SlicesTop = (1 << SlicesW) - 1;
  // slice clamp limited to what the slices register can hold
  localparam logic [SlicesW-1:0] MaxS = (MAX_SLICES > SlicesTop) ?
                                        SlicesW'(SlicesTop) : SlicesW'(MAX_SLICES);

  logic [RadiusW-1:0] radius_q;
  logic [LengthW-1:0] length_q;
  logic [SlicesW-1:0] slices_q;
  logic [AddrW-1:0]   reg_addr;

  // configuration registers
  assign pready = 1'b1;
  assign reg_addr = {paddr[AddrW-1:2], 2'b00};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusW'(256);
      length_q <= LengthW'(512);
      slices_q <= SlicesW'(16);
    end else if (psel && penable && pwrite) begin
      case (reg_addr)
        RegRadius: radius_q <= pwdata[RadiusW-1:0];
        RegLength: length_q <= pwdata[LengthW-1:0];
        RegSlices: slices_q <= pwdata[SlicesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_addr)
      RegRadius: prdata = {17'd0, radius_q};
      RegLength: prdata = {16'd0, length_q};
      RegSlices: prdata = {23'd0, slices_q};
      default:   prdata = '0;
    endcase
  end

  // chain advance
  logic  out_valid_q;
  logic  en;
  assign en = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  // decode the vertex number
  logic [SlicesW-1:0] s;
  logic [VnumW+1:0]   v, k1, k2;
  logic [VnumW+1:0]   sx, lim_b, lim_p, lim_n;
  logic signed [15:0] half;
  cell_t              dc;
  logic [8:0]         di;
  logic               dneg;

  always_comb begin
    s = (slices_q < SlicesW'(3)) ? SlicesW'(3) :
        (slices_q > MaxS) ? MaxS : slices_q;
    sx = (VnumW+2)'(s);
    lim_b = (sx << 1) + (VnumW+2)'(2);
    lim_p = lim_b + sx + (VnumW+2)'(2);
    lim_n = lim_p + sx + (VnumW+2)'(2);
    v = (VnumW+2)'(in_if.vertex_number);
    k1 = v - lim_b;
    k2 = v - lim_p;
    half = 16'(length_q >> 1);
    dc = '0;
    dc.valid = in_if.valid;
    dc.radius = radius_q;
    di = '0;
    dneg = 1'b1;
    if (v < lim_b) begin
      di = 9'(v >> 1);
      dc.pos_z = v[0] ? -half : half;
      dc.ok = 1'b1;
      dc.body = 1'b1;
      if (di == s) begin
        dc.pos_x = 16'(radius_q); dc.norm_x = 16'sd16384;
      end else dc.rim = 1'b1;
    end else if (v < lim_p) begin
      dc.pos_z = half; dc.norm_z = 16'sd16384; dc.ok = 1'b1;
      if (k1 == sx + (VnumW+2)'(1)) dc.pos_x = 16'(radius_q);
      else if (k1 != '0) begin di = 9'(k1 - (VnumW+2)'(1)); dc.rim = 1'b1; end
    end else if (v < lim_n) begin
      dc.pos_z = -half; dc.norm_z = -16'sd16384; dc.ok = 1'b1; dneg = 1'b0;
      if (k2 == sx + (VnumW+2)'(1)) dc.pos_x = 16'(radius_q);
      else if (k2 != '0) begin di = 9'(k2 - (VnumW+2)'(1)); dc.rim = 1'b1; end
    end
  end

  // decode register, start of the divider chain
  cell_t       dv_c   [DivN+1];
  logic [9:0]  dv_rem [DivN+1];
  logic [31:0] dv_quo [DivN+1];
  logic [8:0]  dv_div [DivN+1];
  logic        dv_neg [DivN+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_c[0]   <= '0;
      dv_rem[0] <= '0;
      dv_quo[0] <= '0;
      dv_div[0] <= '0;
      dv_neg[0] <= 1'b0;
    end else if (en) begin
      dv_c[0]   <= dc;
      dv_rem[0] <= {1'b0, di};
      dv_quo[0] <= '0;
      dv_div[0] <= s;
      dv_neg[0] <= dneg;
    end
  end

  for (genvar g = 0; g < DivN; g++) begin : g_div
    cvg_div_cell u_div (
      .clk_i, .rst_ni, .en_i(en),
      .c_i(dv_c[g]), .rem_i(dv_rem[g]), .quo_i(dv_quo[g]),
      .div_i(dv_div[g]), .neg_i(dv_neg[g]),
      .c_o(dv_c[g+1]), .rem_o(dv_rem[g+1]), .quo_o(dv_quo[g+1]),
      .div_o(dv_div[g+1]), .neg_o(dv_neg[g+1])
    );
  end

  // angle into the CORDIC start vector
  cell_t       cs [CordicSteps+1];
  logic [31:0] ang;
  always_comb begin
    ang = dv_neg[DivN] ? (32'd0 - dv_quo[DivN]) : dv_quo[DivN];
    cs[0] = dv_c[DivN];
    cs[0].quad = ang[31:30];
    cs[0].x = CordicGain;
    cs[0].y = '0;
    cs[0].z = {4'd0, ang[29:0]};
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cor
    cvg_cordic_cell #(.K(g)) u_cor (
      .clk_i, .rst_ni, .en_i(en), .c_i(cs[g]), .c_o(cs[g+1])
    );
  end

  // quadrant map, product with radius
  cell_t              qn, qc;
  logic signed [33:0] cc, ss;
  logic signed [33:0] cq, sq;
  logic signed [50:0] pxq, pyq;

  always_comb begin
    cc = cs[CordicSteps].x;
    ss = cs[CordicSteps].y;
    case (cs[CordicSteps].quad)
      2'd0: begin cq = cc;  sq = ss;  end
      2'd1: begin cq = -ss; sq = cc;  end
      2'd2: begin cq = -cc; sq = -ss; end
      default: begin cq = ss; sq = -cc; end
    endcase
    qn = cs[CordicSteps];
    qn.x = cq;
    qn.y = sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc  <= '0;
      pxq <= '0;
      pyq <= '0;
    end else if (en) begin
      qc  <= qn;
      pxq <= 51'(cq) * $signed({36'd0, cs[CordicSteps].radius});
      pyq <= 51'(sq) * $signed({36'd0, cs[CordicSteps].radius});
    end
  end

  // rounding, saturation and output register
  function automatic logic signed [15:0] sat(input logic signed [50:0] v,
                                             input logic signed [15:0] lim);
    logic signed [50:0] l;
    l = 51'(lim);
    if (v > l) sat = lim;
    else if (v < -l) sat = -lim;
    else sat = v[15:0];
  endfunction

  logic signed [50:0] rx, ry, nx, ny;
  always_comb begin
    rx = (pxq + (51'sd1 <<< 29)) >>> 30;
    ry = (pyq + (51'sd1 <<< 29)) >>> 30;
    nx = (51'(qc.x) + (51'sd1 <<< 15)) >>> 16;
    ny = (51'(qc.y) + (51'sd1 <<< 15)) >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= qc.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_if.pos_z    <= qc.pos_z;
      out_if.norm_z   <= qc.norm_z;
      out_if.index_ok <= qc.ok;
      if (qc.rim) begin
        out_if.pos_x  <= sat(rx, 16'sd32767);
        out_if.pos_y  <= sat(ry, 16'sd32767);
        out_if.norm_x <= qc.body ? sat(nx, 16'sd16384) : 16'sd0;
        out_if.norm_y <= qc.body ? sat(ny, 16'sd16384) : 16'sd0;
      end else begin
        out_if.pos_x  <= qc.pos_x;
        out_if.pos_y  <= '0;
        out_if.norm_x <= qc.norm_x;
        out_if.norm_y <= '0;
      end
    end
  end
  assign out_if.valid = out_valid_q;

`ifndef NO_ASSERTIONS
  // a held result beat must stay valid and keep its pos_x under backpressure
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.pos_x))
    else $error("result changed while stalled");
  // input is refused only when output is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input refused without stall");
  // out-of-range results carry zero pos_z, norm_z and pos_x
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.index_ok |-> out_if.pos_z == 16'sd0 &&
    out_if.norm_z == 16'sd0 && out_if.pos_x == 16'sd0)
    else $error("out-of-range result not zero");
`endif

endmodule

`default_nettype wire
